// ===== src/blcc_pkg.sv =====
// shared types, codes and helper functions for the box line crossing check
`timescale 1ns / 1ps
package blcc_pkg;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned ID_BITS      = 16;
  localparam int unsigned COUNT_BITS   = 8;
  localparam int unsigned RULE_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [COUNT_BITS-1:0] TRACE_MIN = COUNT_BITS'(3);

  typedef logic [COORD_BITS-1:0]            coord_t;
  typedef logic [COORD_BITS:0]              ecoord_t;   // coordinate plus size, never wraps
  typedef logic signed [COORD_BITS:0]       ldiff_t;    // line delta
  typedef logic signed [COORD_BITS+1:0]     cdiff_t;    // corner minus line end
  typedef logic signed [2*COORD_BITS+2:0]   prod_t;
  typedef logic signed [2*COORD_BITS+3:0]   orient_t;
  typedef logic [RULE_BITS-1:0]             rule_t;
  typedef logic [CFG_IDX_BITS-1:0]          cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_LINE_START_X = CFG_IDX_BITS'(0);
  localparam cfg_idx_t CFG_LINE_START_Y = CFG_IDX_BITS'(1);
  localparam cfg_idx_t CFG_LINE_END_X   = CFG_IDX_BITS'(2);
  localparam cfg_idx_t CFG_LINE_END_Y   = CFG_IDX_BITS'(3);
  localparam cfg_idx_t CFG_LINE_RULE    = CFG_IDX_BITS'(4);

  // alert rules
  localparam rule_t RULE_ANY   = RULE_BITS'(0);
  localparam rule_t RULE_RIGHT = RULE_BITS'(1);
  localparam rule_t RULE_LEFT  = RULE_BITS'(2);
  localparam rule_t RULE_DOWN  = RULE_BITS'(3);
  localparam rule_t RULE_UP    = RULE_BITS'(4);

  // orientation codes
  typedef logic [1:0] turn_t;
  localparam turn_t TURN_COL = 2'd0;
  localparam turn_t TURN_POS = 2'd1;
  localparam turn_t TURN_NEG = 2'd2;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef struct packed {
    logic               confirmed;
    logic               right;
    logic               left;
    logic               down;
    logic               up;
    logic [ID_BITS-1:0] id;
  } side_t;

  // line endpoints seen from one box edge
  typedef struct packed {
    turn_t turn_ls;
    turn_t turn_le;
    logic  ls_on;
    logic  le_on;
  } edge_t;

  // orientation of a point against an axis-aligned edge; no multiply needed
  function automatic turn_t edge_turn(logic degenerate, ecoord_t c, ecoord_t r,
                                      logic pos_if_below);
    turn_t t;
    if (degenerate || (c == r)) begin
      t = TURN_COL;
    end else if ((c < r) == pos_if_below) begin
      t = TURN_POS;
    end else begin
      t = TURN_NEG;
    end
    return t;
  endfunction

  function automatic logic seg_meet(turn_t t1, turn_t t2, edge_t e, logic w1, logic w2);
    logic m;
    m = ((t1 != t2) && (e.turn_ls != e.turn_le)) ||
        ((t1 == TURN_COL) && w1) || ((t2 == TURN_COL) && w2) ||
        ((e.turn_ls == TURN_COL) && e.ls_on) || ((e.turn_le == TURN_COL) && e.le_on);
    return m;
  endfunction

endpackage

// ===== src/blcc_in_if.sv =====
// box transaction channel
`timescale 1ns / 1ps
interface blcc_in_if;
  logic                          valid;
  logic                          ready;
  blcc_pkg::coord_t              box_x;
  blcc_pkg::coord_t              box_y;
  blcc_pkg::coord_t              box_width;
  blcc_pkg::coord_t              box_height;
  logic                          track_confirmed;
  logic [blcc_pkg::COUNT_BITS-1:0] trace_count;
  blcc_pkg::coord_t              recent_x;
  blcc_pkg::coord_t              recent_y;
  blcc_pkg::coord_t              earlier_x;
  blcc_pkg::coord_t              earlier_y;
  logic [blcc_pkg::ID_BITS-1:0]  track_id;

  modport source (
    output valid, box_x, box_y, box_width, box_height, track_confirmed, trace_count,
           recent_x, recent_y, earlier_x, earlier_y, track_id,
    input  ready
  );
  modport sink (
    input  valid, box_x, box_y, box_width, box_height, track_confirmed, trace_count,
           recent_x, recent_y, earlier_x, earlier_y, track_id,
    output ready
  );
endinterface

// ===== src/blcc_out_if.sv =====
// result transaction channel
`timescale 1ns / 1ps
interface blcc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         alert;
  logic                         crossing;
  logic [blcc_pkg::ID_BITS-1:0] alert_id;

  modport source (
    output valid, alert, crossing, alert_id,
    input  ready
  );
  modport sink (
    input  valid, alert, crossing, alert_id,
    output ready
  );
endinterface

// ===== src/blcc_corner_turn.sv =====
// orientation of one box corner against the line, three register stages
`timescale 1ns / 1ps
module blcc_corner_turn (
  input  logic                clk_i,
  input  blcc_pkg::stage_en_t en_i,
  input  blcc_pkg::ecoord_t   cx_i,
  input  blcc_pkg::ecoord_t   cy_i,
  input  blcc_pkg::coord_t    lex_i,
  input  blcc_pkg::coord_t    ley_i,
  input  blcc_pkg::ldiff_t    dx_i,
  input  blcc_pkg::ldiff_t    dy_i,
  output blcc_pkg::turn_t     turn_o
);

  blcc_pkg::cdiff_t  ddx_q, ddy_q;
  blcc_pkg::prod_t   p1_q, p2_q;
  blcc_pkg::orient_t v;
  blcc_pkg::turn_t   turn_q, turn_d;

  always_comb begin
    v = blcc_pkg::orient_t'(p1_q) - blcc_pkg::orient_t'(p2_q);
    if (v == '0) begin
      turn_d = blcc_pkg::TURN_COL;
    end else if (!v[$bits(v)-1]) begin
      turn_d = blcc_pkg::TURN_POS;
    end else begin
      turn_d = blcc_pkg::TURN_NEG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ddx_q <= $signed({1'b0, cx_i}) - $signed({2'b00, lex_i});
      ddy_q <= $signed({1'b0, cy_i}) - $signed({2'b00, ley_i});
    end
    if (en_i.s3) begin
      p1_q <= blcc_pkg::prod_t'(dy_i) * blcc_pkg::prod_t'(ddx_q);
      p2_q <= blcc_pkg::prod_t'(dx_i) * blcc_pkg::prod_t'(ddy_q);
    end
    if (en_i.s4) begin
      turn_q <= turn_d;
    end
  end

  assign turn_o = turn_q;

endmodule

// ===== src/box_line_crossing_check_unit.sv =====
// top level of the box line crossing check
`timescale 1ns / 1ps
// Checks one tracked box per transaction against a configured line segment.
// box_i carries the box, track flags, trace length and two trace points;
// res_o returns alert, crossing and the track id, one result per box, in order.
// The line endpoints and alert rule are to be written by the user through cfg_we_i/cfg_idx_i/
// cfg_data_i only while no box is in flight, which the block does not enforce; unknown indexes are ignored.
// From acceptance to result valid a box passes the register stages:
// box corners, corner deltas and edge tests, the corner products,
// the orientation signs, and the output register holding the decision.
// Boxes go in one per cycle unless a stalled receiver has filled every stage;
// the corner products of stage three are fully parallel, four units with two multipliers each.
// Each stage holds its own valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver fills the bubbles first and box_i.ready
// only drops once every stage holds a transaction; nothing is lost or repeated.
// Reset clears all valid bits and the line registers to zero (rule: any).
module box_line_crossing_check_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  blcc_pkg::cfg_idx_t   cfg_idx_i,
  input  blcc_pkg::coord_t     cfg_data_i,
  blcc_in_if.sink              box_i,
  blcc_out_if.source           res_o
);

  localparam int unsigned NCORNER = 4;
  localparam int unsigned NEDGE   = 4;

  // configuration
  blcc_pkg::coord_t lsx_q, lsy_q, lex_q, ley_q;
  blcc_pkg::rule_t  rule_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsx_q  <= '0;
      lsy_q  <= '0;
      lex_q  <= '0;
      ley_q  <= '0;
      rule_q <= blcc_pkg::RULE_ANY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        blcc_pkg::CFG_LINE_START_X: lsx_q  <= cfg_data_i;
        blcc_pkg::CFG_LINE_START_Y: lsy_q  <= cfg_data_i;
        blcc_pkg::CFG_LINE_END_X:   lex_q  <= cfg_data_i;
        blcc_pkg::CFG_LINE_END_Y:   ley_q  <= cfg_data_i;
        blcc_pkg::CFG_LINE_RULE:    rule_q <= cfg_data_i[blcc_pkg::RULE_BITS-1:0];
        default: ;
      endcase
    end
  end

  blcc_pkg::ldiff_t  dx, dy;
  blcc_pkg::ecoord_t lsx_e, lsy_e, lex_e, ley_e;
  blcc_pkg::ecoord_t lx_min, lx_max, ly_min, ly_max;

  assign dx    = $signed({1'b0, lex_q}) - $signed({1'b0, lsx_q});
  assign dy    = $signed({1'b0, ley_q}) - $signed({1'b0, lsy_q});
  assign lsx_e = {1'b0, lsx_q};
  assign lsy_e = {1'b0, lsy_q};
  assign lex_e = {1'b0, lex_q};
  assign ley_e = {1'b0, ley_q};
  assign lx_min = (lsx_e < lex_e) ? lsx_e : lex_e;
  assign lx_max = (lsx_e < lex_e) ? lex_e : lsx_e;
  assign ly_min = (lsy_e < ley_e) ? lsy_e : ley_e;
  assign ly_max = (lsy_e < ley_e) ? ley_e : lsy_e;

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  blcc_pkg::stage_en_t en;

  assign rdy5 = !v5_q || res_o.ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign box_i.ready = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= box_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  // stage 1: box corners and direction flags
  blcc_pkg::ecoord_t bx_q, by_q, bxr_q, byb_q;
  logic              bw_zero_q, bh_zero_q;
  blcc_pkg::side_t   side1_q, side2_q, side3_q, side4_q;
  logic              dir_ok;

  assign dir_ok = box_i.trace_count > blcc_pkg::TRACE_MIN;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      bx_q      <= {1'b0, box_i.box_x};
      by_q      <= {1'b0, box_i.box_y};
      bxr_q     <= {1'b0, box_i.box_x} + {1'b0, box_i.box_width};
      byb_q     <= {1'b0, box_i.box_y} + {1'b0, box_i.box_height};
      bw_zero_q <= (box_i.box_width == '0);
      bh_zero_q <= (box_i.box_height == '0);
      side1_q.confirmed <= box_i.track_confirmed;
      side1_q.right     <= dir_ok && (box_i.recent_x > box_i.earlier_x);
      side1_q.left      <= dir_ok && (box_i.earlier_x > box_i.recent_x);
      side1_q.down      <= dir_ok && (box_i.recent_y > box_i.earlier_y);
      side1_q.up        <= dir_ok && (box_i.earlier_y > box_i.recent_y);
      side1_q.id        <= box_i.track_id;
    end
  end

  // corners: top-left, top-right, bottom-left, bottom-right
  blcc_pkg::ecoord_t cx [NCORNER];
  blcc_pkg::ecoord_t cy [NCORNER];
  blcc_pkg::turn_t   cturn [NCORNER];

  assign cx[0] = bx_q;
  assign cy[0] = by_q;
  assign cx[1] = bxr_q;
  assign cy[1] = by_q;
  assign cx[2] = bx_q;
  assign cy[2] = byb_q;
  assign cx[3] = bxr_q;
  assign cy[3] = byb_q;

  for (genvar g = 0; g < NCORNER; g++) begin : g_corner
    blcc_corner_turn u_turn (
      .clk_i  (clk_i),
      .en_i   (en),
      .cx_i   (cx[g]),
      .cy_i   (cy[g]),
      .lex_i  (lex_q),
      .ley_i  (ley_q),
      .dx_i   (dx),
      .dy_i   (dy),
      .turn_o (cturn[g])
    );
  end

  // stage 2: edge orientations and bounding box tests
  // edges: top, bottom, left, right
  logic [NCORNER-1:0] con_d, con2_q, con3_q, con4_q;
  blcc_pkg::edge_t    edge_d [NEDGE];
  blcc_pkg::edge_t    edge2_q [NEDGE];
  blcc_pkg::edge_t    edge3_q [NEDGE];
  blcc_pkg::edge_t    edge4_q [NEDGE];

  always_comb begin
    for (int i = 0; i < NCORNER; i++) begin
      con_d[i] = (cx[i] >= lx_min) && (cx[i] <= lx_max) &&
                 (cy[i] >= ly_min) && (cy[i] <= ly_max);
    end
    // horizontal edges: positive when the point lies above the edge
    edge_d[0].turn_ls = blcc_pkg::edge_turn(bw_zero_q, lsy_e, by_q, 1'b1);
    edge_d[0].turn_le = blcc_pkg::edge_turn(bw_zero_q, ley_e, by_q, 1'b1);
    edge_d[0].ls_on   = (lsy_e == by_q) && (lsx_e >= bx_q) && (lsx_e <= bxr_q);
    edge_d[0].le_on   = (ley_e == by_q) && (lex_e >= bx_q) && (lex_e <= bxr_q);
    edge_d[1].turn_ls = blcc_pkg::edge_turn(bw_zero_q, lsy_e, byb_q, 1'b1);
    edge_d[1].turn_le = blcc_pkg::edge_turn(bw_zero_q, ley_e, byb_q, 1'b1);
    edge_d[1].ls_on   = (lsy_e == byb_q) && (lsx_e >= bx_q) && (lsx_e <= bxr_q);
    edge_d[1].le_on   = (ley_e == byb_q) && (lex_e >= bx_q) && (lex_e <= bxr_q);
    // vertical edges: positive when the point lies right of the edge
    edge_d[2].turn_ls = blcc_pkg::edge_turn(bh_zero_q, lsx_e, bx_q, 1'b0);
    edge_d[2].turn_le = blcc_pkg::edge_turn(bh_zero_q, lex_e, bx_q, 1'b0);
    edge_d[2].ls_on   = (lsx_e == bx_q) && (lsy_e >= by_q) && (lsy_e <= byb_q);
    edge_d[2].le_on   = (lex_e == bx_q) && (ley_e >= by_q) && (ley_e <= byb_q);
    edge_d[3].turn_ls = blcc_pkg::edge_turn(bh_zero_q, lsx_e, bxr_q, 1'b0);
    edge_d[3].turn_le = blcc_pkg::edge_turn(bh_zero_q, lex_e, bxr_q, 1'b0);
    edge_d[3].ls_on   = (lsx_e == bxr_q) && (lsy_e >= by_q) && (lsy_e <= byb_q);
    edge_d[3].le_on   = (lex_e == bxr_q) && (ley_e >= by_q) && (ley_e <= byb_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      con2_q  <= con_d;
      edge2_q <= edge_d;
      side2_q <= side1_q;
    end
    if (rdy3) begin
      con3_q  <= con2_q;
      edge3_q <= edge2_q;
      side3_q <= side2_q;
    end
    if (rdy4) begin
      con4_q  <= con3_q;
      edge4_q <= edge3_q;
      side4_q <= side3_q;
    end
  end

  // stage 5: segment tests, crossing and rule
  logic meet_top, meet_bot, meet_lft, meet_rgt;
  logic cross_d, hit;
  logic alert_q, cross_q;
  logic [blcc_pkg::ID_BITS-1:0] id_q;

  assign meet_top = blcc_pkg::seg_meet(cturn[0], cturn[1], edge4_q[0], con4_q[0], con4_q[1]);
  assign meet_bot = blcc_pkg::seg_meet(cturn[2], cturn[3], edge4_q[1], con4_q[2], con4_q[3]);
  assign meet_lft = blcc_pkg::seg_meet(cturn[0], cturn[2], edge4_q[2], con4_q[0], con4_q[2]);
  assign meet_rgt = blcc_pkg::seg_meet(cturn[1], cturn[3], edge4_q[3], con4_q[1], con4_q[3]);
  assign cross_d  = (meet_top && meet_bot) || (meet_lft && meet_rgt);

  always_comb begin
    case (rule_q)
      blcc_pkg::RULE_ANY:   hit = 1'b1;
      blcc_pkg::RULE_RIGHT: hit = side4_q.right;
      blcc_pkg::RULE_LEFT:  hit = side4_q.left;
      blcc_pkg::RULE_DOWN:  hit = side4_q.down;
      blcc_pkg::RULE_UP:    hit = side4_q.up;
      default:              hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      alert_q <= cross_d && side4_q.confirmed && hit;
      cross_q <= cross_d;
      id_q    <= side4_q.id;
    end
  end

  assign res_o.valid    = v5_q;
  assign res_o.alert    = alert_q;
  assign res_o.crossing = cross_q;
  assign res_o.alert_id = id_q;

endmodule

// ===== sim/box_line_crossing_check_unit_tb.sv =====
// self-checking testbench for the box line crossing check unit
`timescale 1ns / 1ps
module box_line_crossing_check_unit_tb;

  localparam int unsigned       CYCLE_LIMIT     = 400000;
  localparam int unsigned       PHASES          = 10;
  localparam int unsigned       BOXES_PER_PHASE = 115;
  localparam int unsigned       MAX_REPORTS     = 30;
  localparam int unsigned       TAIL_CYCLES     = 12;
  localparam blcc_pkg::coord_t  COORD_MAX       = '1;

  typedef logic [blcc_pkg::COUNT_BITS-1:0] count_t;
  typedef logic [blcc_pkg::ID_BITS-1:0]    id_t;

  // indexes past the register list, writes there must be ignored
  localparam blcc_pkg::cfg_idx_t CFG_SPARE_LO = blcc_pkg::cfg_idx_t'(5);
  localparam blcc_pkg::cfg_idx_t CFG_SPARE_HI = blcc_pkg::cfg_idx_t'(7);
  // a rule code that never alerts
  localparam blcc_pkg::rule_t RULE_OFF_HI = blcc_pkg::rule_t'(7);

  typedef struct packed {
    blcc_pkg::coord_t box_x;
    blcc_pkg::coord_t box_y;
    blcc_pkg::coord_t box_width;
    blcc_pkg::coord_t box_height;
    logic             track_confirmed;
    count_t           trace_count;
    blcc_pkg::coord_t recent_x;
    blcc_pkg::coord_t recent_y;
    blcc_pkg::coord_t earlier_x;
    blcc_pkg::coord_t earlier_y;
    id_t              track_id;
  } box_t;

  typedef struct packed {
    logic alert;
    logic crossing;
    id_t  alert_id;
  } verdict_t;

  typedef struct {
    bit                 is_cfg;
    blcc_pkg::cfg_idx_t idx;
    blcc_pkg::coord_t   data;
    box_t               box;
    bit                 typed;
    verdict_t           want;
  } row_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  blcc_pkg::cfg_idx_t cfg_idx_i;
  blcc_pkg::coord_t   cfg_data_i;

  blcc_in_if  box_if ();
  blcc_out_if res_if ();

  box_line_crossing_check_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .box_i      (box_if),
    .res_o      (res_if)
  );

  // line registers as the block should hold them
  blcc_pkg::coord_t line_sx   = '0;
  blcc_pkg::coord_t line_sy   = '0;
  blcc_pkg::coord_t line_ex   = '0;
  blcc_pkg::coord_t line_ey   = '0;
  blcc_pkg::rule_t  line_rule = blcc_pkg::RULE_ANY;

  verdict_t    pending_verdicts[$];
  row_t        bench_rows[$];
  bit          quiet      = 1'b0;
  int unsigned n_boxes    = 0;
  int unsigned n_results  = 0;
  int unsigned n_cross    = 0;
  int unsigned n_alert    = 0;
  int unsigned n_fail     = 0;
  int unsigned n_settings = 0;
  int unsigned cycle_cnt  = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // orientation of c seen from segment a-b
  function automatic blcc_pkg::turn_t orient(point_t a, point_t b, point_t c);
    longint v;
    v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
    if (v == 0) return blcc_pkg::TURN_COL;
    return (v > 0) ? blcc_pkg::TURN_POS : blcc_pkg::TURN_NEG;
  endfunction

  // q inside the bounding rectangle of p and r
  function automatic bit on_span(point_t p, point_t q, point_t r);
    return q.x <= ((p.x > r.x) ? p.x : r.x) && q.x >= ((p.x < r.x) ? p.x : r.x) &&
           q.y <= ((p.y > r.y) ? p.y : r.y) && q.y >= ((p.y < r.y) ? p.y : r.y);
  endfunction

  function automatic bit touches(point_t a1, point_t b1, point_t a2, point_t b2);
    blcc_pkg::turn_t t1, t2, t3, t4;
    t1 = orient(a1, b1, a2);
    t2 = orient(a1, b1, b2);
    t3 = orient(a2, b2, a1);
    t4 = orient(a2, b2, b1);
    if (t1 != t2 && t3 != t4) return 1'b1;
    return (t1 == blcc_pkg::TURN_COL && on_span(a1, a2, b1)) ||
           (t2 == blcc_pkg::TURN_COL && on_span(a1, b2, b1)) ||
           (t3 == blcc_pkg::TURN_COL && on_span(a2, a1, b2)) ||
           (t4 == blcc_pkg::TURN_COL && on_span(a2, b1, b2));
  endfunction

  function automatic verdict_t crossing_verdict(box_t b);
    point_t   ls, le, tl, tr, bl, br;
    bit       moving, hit;
    verdict_t v;
    ls.x = line_sx;  ls.y = line_sy;
    le.x = line_ex;  le.y = line_ey;
    // far edges are one bit wider and never wrap
    tl.x = b.box_x;               tl.y = b.box_y;
    tr.x = tl.x + b.box_width;    tr.y = tl.y;
    bl.x = tl.x;                  bl.y = tl.y + b.box_height;
    br.x = tr.x;                  br.y = bl.y;
    v.crossing = (touches(ls, le, tl, tr) && touches(ls, le, bl, br)) ||
                 (touches(ls, le, tl, bl) && touches(ls, le, tr, br));
    moving = b.trace_count > blcc_pkg::TRACE_MIN;
    case (line_rule)
      blcc_pkg::RULE_ANY:   hit = 1'b1;
      blcc_pkg::RULE_RIGHT: hit = moving && (b.recent_x > b.earlier_x);
      blcc_pkg::RULE_LEFT:  hit = moving && (b.earlier_x > b.recent_x);
      blcc_pkg::RULE_DOWN:  hit = moving && (b.recent_y > b.earlier_y);
      blcc_pkg::RULE_UP:    hit = moving && (b.earlier_y > b.recent_y);
      default:              hit = 1'b0;
    endcase
    v.alert    = v.crossing && b.track_confirmed && hit;
    v.alert_id = b.track_id;
    return v;
  endfunction

  function automatic box_t mk_box(int x, int y, int w, int h, bit conf, int cnt,
                                  int rx, int ry, int ex, int ey, int id);
    box_t b;
    b.box_x           = blcc_pkg::coord_t'(x);
    b.box_y           = blcc_pkg::coord_t'(y);
    b.box_width       = blcc_pkg::coord_t'(w);
    b.box_height      = blcc_pkg::coord_t'(h);
    b.track_confirmed = conf;
    b.trace_count     = count_t'(cnt);
    b.recent_x        = blcc_pkg::coord_t'(rx);
    b.recent_y        = blcc_pkg::coord_t'(ry);
    b.earlier_x       = blcc_pkg::coord_t'(ex);
    b.earlier_y       = blcc_pkg::coord_t'(ey);
    b.track_id        = id_t'(id);
    return b;
  endfunction

  function automatic void add_box(box_t b, bit typed, bit alert, bit crossed);
    row_t row;
    row.is_cfg = 1'b0;
    row.idx    = blcc_pkg::CFG_LINE_START_X;
    row.data   = '0;
    row.box    = b;
    row.typed  = typed;
    row.want   = '{alert, crossed, b.track_id};
    bench_rows.insert(bench_rows.size(), row);
  endfunction

  function automatic void add_cfg(blcc_pkg::cfg_idx_t idx, blcc_pkg::coord_t data);
    row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.box    = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    bench_rows.insert(bench_rows.size(), row);
  endfunction

  function automatic int pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, 4095);
    return $urandom_range(1, 80);
  endfunction

  // mostly boxes straddling a point of the line, some noise and extremes
  function automatic box_t gen_box();
    box_t        b;
    int unsigned r, t;
    int          px, py, w, h, x, y;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      t  = $urandom_range(0, 64);
      px = int'(line_sx) + (int'(line_ex) - int'(line_sx)) * int'(t) / 64;
      py = int'(line_sy) + (int'(line_ey) - int'(line_sy)) * int'(t) / 64;
      w  = pick_size();
      h  = pick_size();
      if ($urandom_range(0, 9) == 0) begin
        x = px;
        y = py;
      end else begin
        x = px - int'($urandom_range(0, w));
        y = py - int'($urandom_range(0, h));
        if (x < 0) x = 0;
        if (y < 0) y = 0;
      end
      b.box_x      = blcc_pkg::coord_t'(x);
      b.box_y      = blcc_pkg::coord_t'(y);
      b.box_width  = blcc_pkg::coord_t'(w);
      b.box_height = blcc_pkg::coord_t'(h);
    end else if (r < 95) begin
      b.box_x      = blcc_pkg::coord_t'($urandom);
      b.box_y      = blcc_pkg::coord_t'($urandom);
      b.box_width  = blcc_pkg::coord_t'($urandom);
      b.box_height = blcc_pkg::coord_t'($urandom);
    end else begin
      b.box_x      = $urandom_range(0, 1) ? COORD_MAX : '0;
      b.box_y      = $urandom_range(0, 1) ? COORD_MAX : '0;
      b.box_width  = $urandom_range(0, 1) ? COORD_MAX : '0;
      b.box_height = $urandom_range(0, 1) ? COORD_MAX : '0;
    end
    b.track_confirmed = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 9);
    if (r < 3) b.trace_count = count_t'($urandom_range(0, 6));
    else if (r == 3) b.trace_count = '1;
    else b.trace_count = count_t'($urandom);
    b.earlier_x = blcc_pkg::coord_t'($urandom);
    b.earlier_y = blcc_pkg::coord_t'($urandom);
    b.recent_x  = ($urandom_range(0, 4) == 0) ? b.earlier_x : blcc_pkg::coord_t'($urandom);
    b.recent_y  = ($urandom_range(0, 4) == 0) ? b.earlier_y : blcc_pkg::coord_t'($urandom);
    b.track_id  = id_t'($urandom);
    return b;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
  endtask

  // called at a falling edge while no transaction is in flight
  task automatic write_reg(blcc_pkg::cfg_idx_t idx, blcc_pkg::coord_t data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      blcc_pkg::CFG_LINE_START_X: line_sx = data;
      blcc_pkg::CFG_LINE_START_Y: line_sy = data;
      blcc_pkg::CFG_LINE_END_X:   line_ex = data;
      blcc_pkg::CFG_LINE_END_Y:   line_ey = data;
      blcc_pkg::CFG_LINE_RULE:    line_rule = data[blcc_pkg::RULE_BITS-1:0];
      default: ;
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    box_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_box(box_t b, verdict_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      box_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    box_if.box_x           = b.box_x;
    box_if.box_y           = b.box_y;
    box_if.box_width       = b.box_width;
    box_if.box_height      = b.box_height;
    box_if.track_confirmed = b.track_confirmed;
    box_if.trace_count     = b.trace_count;
    box_if.recent_x        = b.recent_x;
    box_if.recent_y        = b.recent_y;
    box_if.earlier_x       = b.earlier_x;
    box_if.earlier_y       = b.earlier_y;
    box_if.track_id        = b.track_id;
    box_if.valid           = 1'b1;
    do @(posedge clk_i); while (box_if.ready !== 1'b1);
    pending_verdicts.insert(pending_verdicts.size(), want);
    n_boxes++;
    @(negedge clk_i);
  endtask

  // result side stalls
  initial begin
    int unsigned gap, stall_left;
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        gap          = pick_gap();
        res_if.ready = (gap == 0);
        stall_left   = (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      n_results++;
      if (res_if.crossing === 1'b1) n_cross++;
      if (res_if.alert === 1'b1) n_alert++;
      if (pending_verdicts.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none got id %0h",
                   $time, res_if.alert_id);
      end else begin
        want = pending_verdicts.pop_front();
        if (res_if.alert !== want.alert) report_mismatch("alert", want.alert, res_if.alert);
        if (res_if.crossing !== want.crossing)
          report_mismatch("crossing", want.crossing, res_if.crossing);
        if (res_if.alert_id !== want.alert_id)
          report_mismatch("alert_id", want.alert_id, res_if.alert_id);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    box_t             b;
    blcc_pkg::coord_t sx, sy, ex, ey;
    blcc_pkg::rule_t  rule;

    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = blcc_pkg::CFG_LINE_START_X;
    cfg_data_i             = '0;
    box_if.valid           = 1'b0;
    box_if.box_x           = '0;
    box_if.box_y           = '0;
    box_if.box_width       = '0;
    box_if.box_height      = '0;
    box_if.track_confirmed = 1'b0;
    box_if.trace_count     = '0;
    box_if.recent_x        = '0;
    box_if.recent_y        = '0;
    box_if.earlier_x       = '0;
    box_if.earlier_y       = '0;
    box_if.track_id        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset the line is a point at the origin, any rule
    add_box(mk_box(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 'h0000), 1, 1, 1);
    add_box(mk_box(1, 1, 5, 5, 1, 0, 0, 0, 0, 0, 'hFFFF), 1, 0, 0);
    // full diagonal
    add_cfg(blcc_pkg::CFG_LINE_START_X, '0);
    add_cfg(blcc_pkg::CFG_LINE_START_Y, '0);
    add_cfg(blcc_pkg::CFG_LINE_END_X, COORD_MAX);
    add_cfg(blcc_pkg::CFG_LINE_END_Y, COORD_MAX);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(blcc_pkg::RULE_ANY));
    add_box(mk_box(100, 100, 50, 50, 1, 0, 0, 0, 0, 0, 'h0001), 0, 0, 0);
    add_box(mk_box(100, 100, 50, 50, 0, 9, 0, 0, 0, 0, 'h0002), 1, 0, 1);
    // far edges past the coordinate range
    add_box(mk_box(4095, 4095, 4095, 4095, 1, 255, 4095, 4095, 4095, 4095, 'h8000), 0, 0, 0);
    add_box(mk_box(0, 0, 4095, 4095, 1, 255, 4095, 4095, 0, 0, 'h7FFF), 0, 0, 0);
    // horizontal line, rule written with junk in the upper data bits
    add_cfg(blcc_pkg::CFG_LINE_START_Y, blcc_pkg::coord_t'(2000));
    add_cfg(blcc_pkg::CFG_LINE_END_Y, blcc_pkg::coord_t'(2000));
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'({9'h1FF, blcc_pkg::RULE_RIGHT}));
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1300, 0, 1200, 0, 'h0010), 0, 0, 0);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 3, 1300, 0, 1200, 0, 'h0011), 1, 0, 1);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 4, 1300, 0, 1200, 0, 'h0012), 0, 0, 0);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1250, 0, 1250, 0, 'h0013), 0, 0, 0);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1100, 0, 1250, 0, 'h0014), 0, 0, 0);
    add_cfg(CFG_SPARE_LO, COORD_MAX);
    add_cfg(CFG_SPARE_HI, '0);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1300, 0, 1200, 0, 'h0015), 0, 0, 0);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(blcc_pkg::RULE_LEFT));
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1100, 0, 1250, 0, 'h0016), 0, 0, 0);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(blcc_pkg::RULE_DOWN));
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 0, 2100, 0, 1900, 'h0017), 0, 0, 0);
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 0, 1900, 0, 1900, 'h0018), 0, 0, 0);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(blcc_pkg::RULE_UP));
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 0, 1800, 0, 1900, 'h0019), 0, 0, 0);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(RULE_OFF_HI));
    add_box(mk_box(1000, 1500, 500, 1000, 1, 10, 1300, 1800, 1200, 1900, 'h001A), 1, 0, 1);
    add_cfg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'(blcc_pkg::RULE_ANY));
    // edge lying on the line, flat box on the line, box far away
    add_box(mk_box(1000, 2000, 500, 100, 1, 0, 0, 0, 0, 0, 'h001B), 0, 0, 0);
    add_box(mk_box(1000, 2000, 500, 0, 1, 0, 0, 0, 0, 0, 'h001C), 0, 0, 0);
    add_box(mk_box(0, 0, 10, 10, 1, 0, 0, 0, 0, 0, 'h001D), 1, 0, 0);
    // line shrunk to a point
    add_cfg(blcc_pkg::CFG_LINE_START_X, blcc_pkg::coord_t'(500));
    add_cfg(blcc_pkg::CFG_LINE_START_Y, blcc_pkg::coord_t'(500));
    add_cfg(blcc_pkg::CFG_LINE_END_X, blcc_pkg::coord_t'(500));
    add_cfg(blcc_pkg::CFG_LINE_END_Y, blcc_pkg::coord_t'(500));
    add_box(mk_box(400, 400, 200, 200, 1, 0, 0, 0, 0, 0, 'h001E), 0, 0, 0);
    add_box(mk_box(500, 400, 0, 200, 1, 0, 0, 0, 0, 0, 'h001F), 0, 0, 0);
    // vertical line on the right border
    add_cfg(blcc_pkg::CFG_LINE_START_X, COORD_MAX);
    add_cfg(blcc_pkg::CFG_LINE_START_Y, '0);
    add_cfg(blcc_pkg::CFG_LINE_END_X, COORD_MAX);
    add_cfg(blcc_pkg::CFG_LINE_END_Y, COORD_MAX);
    add_box(mk_box(4000, 100, 95, 50, 1, 0, 0, 0, 0, 0, 'h0020), 0, 0, 0);
    add_box(mk_box(4095, 0, 4095, 4095, 1, 0, 0, 0, 0, 0, 'h0021), 0, 0, 0);

    foreach (bench_rows[i]) begin
      if (bench_rows[i].is_cfg) begin
        settle();
        write_reg(bench_rows[i].idx, bench_rows[i].data);
      end else begin
        send_box(bench_rows[i].box,
                 bench_rows[i].typed ? bench_rows[i].want : crossing_verdict(bench_rows[i].box));
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      quiet = (p % 3 == 2);
      case (p)
        0: begin
          sx = '0;  sy = '0;  ex = COORD_MAX;  ey = COORD_MAX;
        end
        1: begin
          sx = COORD_MAX;  sy = '0;  ex = '0;  ey = COORD_MAX;
        end
        2: begin
          sx = blcc_pkg::coord_t'($urandom);  sy = blcc_pkg::coord_t'($urandom);
          ex = sx;  ey = sy;
        end
        3: begin
          sx = blcc_pkg::coord_t'($urandom);  ex = blcc_pkg::coord_t'($urandom);
          sy = blcc_pkg::coord_t'($urandom);  ey = sy;
        end
        4: begin
          sy = blcc_pkg::coord_t'($urandom);  ey = blcc_pkg::coord_t'($urandom);
          sx = blcc_pkg::coord_t'($urandom);  ex = sx;
        end
        default: begin
          sx = blcc_pkg::coord_t'($urandom);  sy = blcc_pkg::coord_t'($urandom);
          ex = blcc_pkg::coord_t'($urandom);  ey = blcc_pkg::coord_t'($urandom);
        end
      endcase
      rule = (p < 8) ? blcc_pkg::rule_t'(p) : blcc_pkg::rule_t'($urandom_range(0, 7));
      write_reg(blcc_pkg::CFG_LINE_START_X, sx);
      write_reg(blcc_pkg::CFG_LINE_START_Y, sy);
      write_reg(blcc_pkg::CFG_LINE_END_X, ex);
      write_reg(blcc_pkg::CFG_LINE_END_Y, ey);
      write_reg(blcc_pkg::CFG_LINE_RULE, blcc_pkg::coord_t'({9'($urandom), rule}));
      if (p % 2 == 1)
        write_reg(blcc_pkg::cfg_idx_t'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  blcc_pkg::coord_t'($urandom));
      n_settings++;
      repeat (BOXES_PER_PHASE) begin
        b = gen_box();
        send_box(b, crossing_verdict(b));
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d boxes: directed edge cases, then %0d random line settings",
             n_boxes, n_settings);
    $display("%0d results with %0d crossings and %0d alerts, %0d mismatches",
             n_results, n_cross, n_alert, n_fail);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/blcc_pkg.sv
src/blcc_in_if.sv
src/blcc_out_if.sv
src/blcc_corner_turn.sv
src/box_line_crossing_check_unit.sv
sim/box_line_crossing_check_unit_tb.sv
